// File: rtl/core/docking_motor_supervisor_core_assert.svh
// Assertion macros for the docking motor supervisor core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DOCKING_MOTOR_SUPERVISOR_CORE_ASSERT_SVH
`define DOCKING_MOTOR_SUPERVISOR_CORE_ASSERT_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define DMS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define DMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMS_ASSERT_SAME(name, ante, cons, msg)
`define DMS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: rtl/core/dms_pkg.sv
// Shared types and constants of the docking motor supervisor core.
// No dependencies.
`timescale 1ns / 1ps
package dms_pkg;

  localparam int CUR_W     = 12;
  localparam int SENSE_W   = 12;
  localparam int BLANK_W   = 10;
  localparam int TIMEOUT_W = 11;
  localparam int CFG_W     = 12;
  localparam int TRIP_W    = 3;

  localparam logic [TRIP_W-1:0] TRIP_LIMIT = 3'd3;
  localparam logic [TRIP_W-1:0] TRIP_MAX   = 3'd7;

  localparam logic [CUR_W-1:0]     RST_CURRENT_LIMIT = 12'd250;
  localparam logic [BLANK_W-1:0]   RST_BLANK_TICKS   = 10'd10;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS = 11'd1024;
  localparam logic [SENSE_W-1:0]   RST_UNDOCKED_MIN  = 12'd3300;
  localparam logic [SENSE_W-1:0]   RST_PWR_ON_MIN    = 12'd3000;
  localparam logic [SENSE_W-1:0]   RST_12V_MIN       = 12'd2500;
  localparam logic [SENSE_W-1:0]   RST_5V_MIN        = 12'd1700;
  localparam logic [SENSE_W-1:0]   RST_PWR_OFF_MAX   = 12'd1100;

  typedef enum logic [2:0] {
    REG_CURRENT_LIMIT = 3'd0,
    REG_BLANK_TICKS   = 3'd1,
    REG_TIMEOUT_TICKS = 3'd2,
    REG_UNDOCKED_MIN  = 3'd3,
    REG_PWR_ON_MIN    = 3'd4,
    REG_12V_MIN       = 3'd5,
    REG_5V_MIN        = 3'd6,
    REG_PWR_OFF_MAX   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_DOCK   = 2'd1,
    CMD_UNDOCK = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  // Run mode doubles as the motor drive code.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DOCK   = 2'd1,
    MODE_UNDOCK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RES_NONE        = 2'd0,
    RES_OK          = 2'd1,
    RES_OVERCURRENT = 2'd2,
    RES_TIMEOUT     = 2'd3
  } res_code_t;

  typedef enum logic [2:0] {
    CLS_UNDOCKED  = 3'd0,
    CLS_PWR_OFF   = 3'd1,
    CLS_PWR_ON    = 3'd2,
    CLS_12V_ON    = 3'd3,
    CLS_5V_ON     = 3'd4,
    CLS_INBETWEEN = 3'd5,
    CLS_UNKNOWN   = 3'd6
  } dock_class_t;

  typedef struct packed {
    logic [CUR_W-1:0]     current_limit;
    logic [BLANK_W-1:0]   blank_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [SENSE_W-1:0]   undocked_min;
    logic [SENSE_W-1:0]   pwr_on_min;
    logic [SENSE_W-1:0]   v12_min;
    logic [SENSE_W-1:0]   v5_min;
    logic [SENSE_W-1:0]   pwr_off_max;
  } cfg_t;

  typedef struct packed {
    mode_t     drive;
    logic      busy;
    logic      done;
    res_code_t code;
  } run_res_t;

endpackage

// File: rtl/core/dms_cfg_regs.sv
// Configuration register file of the docking motor supervisor core.
// Depends on dms_pkg.
`timescale 1ns / 1ps
module dms_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  dms_pkg::reg_idx_t            cfg_idx,
  input  logic [dms_pkg::CFG_W-1:0]    cfg_wdata,
  output dms_pkg::cfg_t                cfg
);
  import dms_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_CURRENT_LIMIT: cfg_nxt.current_limit = cfg_wdata[CUR_W-1:0];
        REG_BLANK_TICKS:   cfg_nxt.blank_ticks   = cfg_wdata[BLANK_W-1:0];
        REG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wdata[TIMEOUT_W-1:0];
        REG_UNDOCKED_MIN:  cfg_nxt.undocked_min  = cfg_wdata[SENSE_W-1:0];
        REG_PWR_ON_MIN:    cfg_nxt.pwr_on_min    = cfg_wdata[SENSE_W-1:0];
        REG_12V_MIN:       cfg_nxt.v12_min       = cfg_wdata[SENSE_W-1:0];
        REG_5V_MIN:        cfg_nxt.v5_min        = cfg_wdata[SENSE_W-1:0];
        REG_PWR_OFF_MAX:   cfg_nxt.pwr_off_max   = cfg_wdata[SENSE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_limit <= RST_CURRENT_LIMIT;
      cfg_r.blank_ticks   <= RST_BLANK_TICKS;
      cfg_r.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg_r.undocked_min  <= RST_UNDOCKED_MIN;
      cfg_r.pwr_on_min    <= RST_PWR_ON_MIN;
      cfg_r.v12_min       <= RST_12V_MIN;
      cfg_r.v5_min        <= RST_5V_MIN;
      cfg_r.pwr_off_max   <= RST_PWR_OFF_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/dms_classify.sv
// Supply sense classifier: maps one sense sample and the end switch to a class.
// Depends on dms_pkg.
`timescale 1ns / 1ps
module dms_classify (
  input  logic [dms_pkg::SENSE_W-1:0] sense,
  input  logic                        end_switch,
  input  dms_pkg::cfg_t               cfg,
  output dms_pkg::dock_class_t        cls
);
  import dms_pkg::*;

  // The thresholds are tried from the top down; the first match wins.
  always_comb begin
    priority if (sense > cfg.undocked_min) begin
      cls = end_switch ? CLS_UNDOCKED : CLS_INBETWEEN;
    end else if (sense > cfg.pwr_on_min) begin
      cls = CLS_PWR_ON;
    end else if (sense > cfg.v12_min) begin
      cls = CLS_12V_ON;
    end else if (sense > cfg.v5_min) begin
      cls = CLS_5V_ON;
    end else if (sense < cfg.pwr_off_max) begin
      cls = CLS_PWR_OFF;
    end else begin
      cls = CLS_UNKNOWN;
    end
  end

endmodule

// File: rtl/core/dms_run_ctrl.sv
// Run controller: run mode, tick counter and overcurrent trip counter.
// Depends on dms_pkg and docking_motor_supervisor_core_assert.svh.
`timescale 1ns / 1ps
`include "docking_motor_supervisor_core_assert.svh"
module dms_run_ctrl #(
  parameter int MAX_RUN_TICKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  dms_pkg::cmd_t               cmd,
  input  logic [dms_pkg::CUR_W-1:0]   motor_current,
  input  logic                        end_switch,
  input  dms_pkg::dock_class_t        cls,
  input  dms_pkg::cfg_t               cfg,
  output dms_pkg::run_res_t           res
);
  import dms_pkg::*;

  localparam int TW = $clog2(MAX_RUN_TICKS + 1);
  localparam int LW = (TW > TIMEOUT_W) ? TW : TIMEOUT_W;
  localparam int BW = (TW > BLANK_W) ? TW : BLANK_W;

  mode_t             run_mode_r, run_mode_nxt;
  logic [TW-1:0]     tick_index_r, tick_index_nxt;
  logic [TRIP_W-1:0] trip_run_r, trip_run_nxt;
  logic              done;
  res_code_t         code;

  logic [LW-1:0] limit;
  logic [LW-1:0] timeout_ext;
  logic [TW-1:0] tick_inc;
  logic          ok;
  logic          over;

  // A zero timeout acts as one tick; anything above the run maximum is clipped.
  assign timeout_ext = LW'(cfg.timeout_ticks);
  always_comb begin
    priority if (timeout_ext == '0) begin
      limit = LW'(1);
    end else if (timeout_ext > LW'(MAX_RUN_TICKS)) begin
      limit = LW'(MAX_RUN_TICKS);
    end else begin
      limit = timeout_ext;
    end
  end

  assign tick_inc = tick_index_r + TW'(1);
  assign ok = (run_mode_r == MODE_DOCK) ?
              (cls != CLS_UNDOCKED && cls != CLS_INBETWEEN) : end_switch;
  assign over = (motor_current > cfg.current_limit) &&
                (BW'(tick_index_r) > BW'(cfg.blank_ticks));

  always_comb begin
    run_mode_nxt   = run_mode_r;
    tick_index_nxt = tick_index_r;
    trip_run_nxt   = trip_run_r;
    done           = 1'b0;
    code           = RES_NONE;
    if (step) begin
      unique case (cmd)
        CMD_DOCK, CMD_UNDOCK: begin
          run_mode_nxt   = (cmd == CMD_DOCK) ? MODE_DOCK : MODE_UNDOCK;
          tick_index_nxt = '0;
          trip_run_nxt   = '0;
        end
        CMD_TICK: begin
          if (run_mode_r != MODE_IDLE) begin
            if (ok) begin
              done = 1'b1;
              code = RES_OK;
            end else begin
              if (over) begin
                trip_run_nxt = (trip_run_r == TRIP_MAX) ? trip_run_r
                                                         : trip_run_r + TRIP_W'(1);
              end else begin
                trip_run_nxt = '0;
              end
              if (trip_run_nxt > TRIP_LIMIT) begin
                done = 1'b1;
                code = RES_OVERCURRENT;
              end else begin
                tick_index_nxt = tick_inc;
                if (LW'(tick_inc) >= limit) begin
                  done = 1'b1;
                  code = RES_TIMEOUT;
                end
              end
            end
            if (done) begin
              run_mode_nxt = MODE_IDLE;
            end
          end
        end
        CMD_QUERY: begin
        end
      endcase
    end
  end

  // The reported drive and busy flag reflect the mode after this item.
  always_comb begin
    res.drive = run_mode_nxt;
    res.busy  = (run_mode_nxt != MODE_IDLE);
    res.done  = done;
    res.code  = code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r   <= MODE_IDLE;
      tick_index_r <= '0;
      trip_run_r   <= '0;
    end else begin
      run_mode_r   <= run_mode_nxt;
      tick_index_r <= tick_index_nxt;
      trip_run_r   <= trip_run_nxt;
    end
  end

  `DMS_ASSERT_SAME(a_done_brakes, res.done, !res.busy && res.drive == MODE_IDLE, "ending must brake")
  `DMS_ASSERT_SAME(a_trip_bound, 1'b1, trip_run_r <= TRIP_LIMIT + TRIP_W'(1), "trip run overflow")
  `DMS_ASSERT_NEXT(a_start_runs, step && (cmd == CMD_DOCK || cmd == CMD_UNDOCK), run_mode_r != MODE_IDLE && tick_index_r == '0, "start must open a run")
  `DMS_ASSERT_NEXT(a_idle_hold, step && cmd == CMD_TICK && run_mode_r == MODE_IDLE, $stable(tick_index_r) && $stable(trip_run_r), "idle tick changed state")

endmodule

// File: rtl/core/docking_motor_supervisor_core.sv
// Docking motor supervisor: one result item per input item.
// One item per clock unless stalled; the input and result registers form a two-stage pipe.
// The result register is updated only when empty or taken, so a stalled result holds.
// Synchronous active-low reset clears the run state, the pipe valids and loads the
// configuration reset values. Depends on dms_pkg and the dms_* submodules.
`timescale 1ns / 1ps
module docking_motor_supervisor_core #(
  parameter int MAX_RUN_TICKS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // motor_current[11:0], supply_sense[23:12], end_switch[24]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // motor_drive[1:0], docking_class[4:2], busy_res[5],
                                  // result_code[7:6]
  output logic        out_tlast,  // done_res
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);
  import dms_pkg::*;

  logic                in_valid_r;
  cmd_t                cmd_r;
  logic [CUR_W-1:0]    cur_r;
  logic [SENSE_W-1:0]  sense_r;
  logic                sw_r;

  logic                out_valid_r;
  logic [7:0]          out_data_r, out_data_nxt;
  logic                out_last_r;

  logic                advance;
  logic                step;
  cfg_t                cfg;
  dock_class_t         cls;
  run_res_t            res;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;

  dms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (reg_idx_t'(cfg_addr)),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dms_classify u_cls (
    .sense      (sense_r),
    .end_switch (sw_r),
    .cfg        (cfg),
    .cls        (cls)
  );

  dms_run_ctrl #(
    .MAX_RUN_TICKS (MAX_RUN_TICKS)
  ) u_run (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cmd           (cmd_r),
    .motor_current (cur_r),
    .end_switch    (sw_r),
    .cls           (cls),
    .cfg           (cfg),
    .res           (res)
  );

  assign out_data_nxt = {res.code, res.busy, cls, res.drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= cmd_t'(in_tuser);
      cur_r   <= in_tdata[11:0];
      sense_r <= in_tdata[23:12];
      sw_r    <= in_tdata[24];
    end
    if (step) begin
      out_data_r <= out_data_nxt;
      out_last_r <= res.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: bench/docking_motor_supervisor_core_test.sv
// Self-checking bench for docking_motor_supervisor_core: directed runs, then random runs.
// It predicts every result item in step with accepted input items and compares field by field.
// Depends on dms_pkg and the core RTL.
`timescale 1ns / 1ps
module docking_motor_supervisor_core_test;
  import dms_pkg::*;

  localparam int RUN_TICK_CAP   = 1024;
  localparam int ITEM_GOAL      = 1700;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    cmd_t        cmd;
    logic [11:0] current;
    logic [11:0] sense;
    logic        end_sw;
  } sample_item_t;

  typedef struct {
    mode_t       drive;
    dock_class_t cls;
    logic        busy;
    logic        done;
    res_code_t   code;
  } supervisor_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // motor_current[11:0], supply_sense[23:12], end_switch[24]
  logic [1:0]  in_tuser = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // motor_drive[1:0], docking_class[4:2], busy_res[5],
                                // result_code[7:6]
  logic        out_tlast;       // done_res
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [11:0] cfg_wdata = '0;

  // Predicted copy of the block's settings and run state.
  logic [11:0]  set_reg [8];
  mode_t        run_mode = MODE_IDLE;
  logic [10:0]  tick_count = '0;
  logic [2:0]   trip_count = '0;

  sample_item_t    pending_items [$];
  supervisor_res_t expected_results [$];
  sample_item_t    bus_item;
  int unsigned     queued_total = 0;
  int unsigned     accepted_total = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     send_gap = 0;
  int unsigned     recv_wait = 0;
  int unsigned     quiet_cycles = 0;
  bit              send_pause_on = 1'b1;
  bit              recv_pause_on = 1'b1;

  docking_motor_supervisor_core #(.MAX_RUN_TICKS(RUN_TICK_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned draw_pause(bit enabled);
    return enabled ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic dock_class_t classify_sense(logic [11:0] sense, logic end_sw);
    if (sense > set_reg[REG_UNDOCKED_MIN])
      return end_sw ? CLS_UNDOCKED : CLS_INBETWEEN;
    if (sense > set_reg[REG_PWR_ON_MIN])
      return CLS_PWR_ON;
    if (sense > set_reg[REG_12V_MIN])
      return CLS_12V_ON;
    if (sense > set_reg[REG_5V_MIN])
      return CLS_5V_ON;
    if (sense < set_reg[REG_PWR_OFF_MAX])
      return CLS_PWR_OFF;
    return CLS_UNKNOWN;
  endfunction

  task automatic predict_supervisor(input sample_item_t it);
    supervisor_res_t r;
    logic [10:0]     cap;
    logic            ok;
    r.cls  = classify_sense(it.sense, it.end_sw);
    r.done = 1'b0;
    r.code = RES_NONE;
    if (it.cmd == CMD_DOCK || it.cmd == CMD_UNDOCK) begin
      run_mode   = (it.cmd == CMD_DOCK) ? MODE_DOCK : MODE_UNDOCK;
      tick_count = '0;
      trip_count = '0;
    end else if (it.cmd == CMD_TICK && run_mode != MODE_IDLE) begin
      cap = set_reg[REG_TIMEOUT_TICKS][10:0];
      if (cap == 11'd0)
        cap = 11'd1;
      if (cap > RUN_TICK_CAP)
        cap = 11'(RUN_TICK_CAP);
      ok = (run_mode == MODE_DOCK) ? (r.cls != CLS_UNDOCKED && r.cls != CLS_INBETWEEN)
                                   : it.end_sw;
      if (ok) begin
        r.done = 1'b1;
        r.code = RES_OK;
      end else begin
        // Over-limit samples only count once the blanking window has passed.
        if (it.current > set_reg[REG_CURRENT_LIMIT] && tick_count > set_reg[REG_BLANK_TICKS]) begin
          if (trip_count != TRIP_MAX)
            trip_count++;
        end else begin
          trip_count = '0;
        end
        if (trip_count > TRIP_LIMIT) begin
          r.done = 1'b1;
          r.code = RES_OVERCURRENT;
        end else begin
          tick_count++;
          if (tick_count >= cap) begin
            r.done = 1'b1;
            r.code = RES_TIMEOUT;
          end
        end
      end
      if (r.done)
        run_mode = MODE_IDLE;
    end
    r.drive = run_mode;
    r.busy  = (run_mode != MODE_IDLE);
    expected_results.push_back(r);
    accepted_total++;
  endtask

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input side: holds an item until taken, then waits its drawn gap before the next one.
  always @(posedge clk) begin : drive_items
    logic hold;
    hold = in_tvalid && !in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_supervisor(bus_item);
      if (!hold) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          bus_item  = pending_items.pop_front();
          in_tdata  <= {7'd0, bus_item.end_sw, bus_item.sense, bus_item.current};
          in_tuser  <= bus_item.cmd;
          in_tvalid <= 1'b1;
          send_gap  <= draw_pause(send_pause_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks every taken item and stalls for a drawn count after each one.
  always @(posedge clk) begin : check_results
    supervisor_res_t want;
    int unsigned     stall;
    stall = recv_wait;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h/%b",
                 $time, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("motor_drive", 3'(want.drive), {1'b0, out_tdata[1:0]});
        check_field("docking_class", want.cls, out_tdata[4:2]);
        check_field("busy_res", {2'b00, want.busy}, {2'b00, out_tdata[5]});
        check_field("done_res", {2'b00, want.done}, {2'b00, out_tlast});
        check_field("result_code", 3'(want.code), {1'b0, out_tdata[7:6]});
      end
      stall = draw_pause(recv_pause_on);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  <= 0;
    end else if (stall != 0) begin
      out_tready <= 1'b0;
      recv_wait  <= stall - 1;
    end else begin
      out_tready <= 1'b1;
      recv_wait  <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(cmd_t cmd, logic [11:0] current, logic [11:0] sense, logic end_sw);
    sample_item_t it;
    it.cmd     = cmd;
    it.current = current;
    it.sense   = sense;
    it.end_sw  = end_sw;
    pending_items.push_back(it);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(reg_idx_t idx, logic [11:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_BLANK_TICKS:   set_reg[idx] = value & 12'h3FF;
      REG_TIMEOUT_TICKS: set_reg[idx] = value & 12'h7FF;
      default:           set_reg[idx] = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] pick_above(logic [11:0] lvl);
    return (lvl == 12'hFFF) ? 12'hFFF : 12'($urandom_range(int'(lvl) + 1, 4095));
  endfunction

  function automatic logic [11:0] pick_setting(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic program_random_settings();
    logic [11:0] lvl [5];
    int unsigned k;
    // Thresholds usually keep their natural order, so every class shows up.
    lvl[4] = 12'($urandom_range(0, 1500));
    lvl[3] = 12'($urandom_range(lvl[4], 2000));
    lvl[2] = 12'($urandom_range(lvl[3], 2800));
    lvl[1] = 12'($urandom_range(lvl[2], 3300));
    lvl[0] = 12'($urandom_range(lvl[1], 4000));
    for (k = 0; k < 5; k++) begin
      if ($urandom_range(0, 5) == 0)
        lvl[k] = 12'($urandom);
    end
    write_setting(REG_CURRENT_LIMIT, pick_setting(100, 3000));
    write_setting(REG_BLANK_TICKS, pick_setting(0, 20));
    write_setting(REG_TIMEOUT_TICKS, ($urandom_range(0, 9) == 0) ? 12'd1024
                                                                  : pick_setting(1, 60));
    write_setting(REG_UNDOCKED_MIN, lvl[0]);
    write_setting(REG_PWR_ON_MIN, lvl[1]);
    write_setting(REG_12V_MIN, lvl[2]);
    write_setting(REG_5V_MIN, lvl[3]);
    write_setting(REG_PWR_OFF_MAX, lvl[4]);
  endtask

  // One start item followed by ticks that mostly keep the run going, with current bursts
  // for overcurrent and occasional samples that end the run, query items and restarts.
  task automatic queue_run(int unsigned n_ticks);
    cmd_t        start_cmd;
    int unsigned i;
    int unsigned burst;
    int unsigned r;
    logic [11:0] current;
    logic [11:0] sense;
    logic        end_sw;
    start_cmd = $urandom_range(0, 1) ? CMD_DOCK : CMD_UNDOCK;
    queue_item(start_cmd, 12'($urandom), 12'($urandom), 1'($urandom));
    burst = 0;
    for (i = 0; i < n_ticks; i++) begin
      if (burst == 0 && $urandom_range(0, 7) == 0)
        burst = $urandom_range(1, 6);
      if (burst != 0) begin
        current = pick_above(set_reg[REG_CURRENT_LIMIT]);
        burst--;
      end else begin
        current = 12'($urandom_range(0, set_reg[REG_CURRENT_LIMIT]));
      end
      sense  = pick_above(set_reg[REG_UNDOCKED_MIN]);
      end_sw = (start_cmd == CMD_DOCK) ? 1'($urandom) : 1'b0;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        sense = 12'($urandom);
      end else if (r < 7) begin
        end_sw = 1'b1;
      end else if (r < 10) begin
        queue_item(CMD_QUERY, 12'($urandom), 12'($urandom), 1'($urandom));
        continue;
      end else if (r == 10) begin
        start_cmd = $urandom_range(0, 1) ? CMD_DOCK : CMD_UNDOCK;
        queue_item(start_cmd, current, sense, end_sw);
        continue;
      end
      queue_item(CMD_TICK, current, sense, end_sw);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    set_reg[REG_CURRENT_LIMIT] = RST_CURRENT_LIMIT;
    set_reg[REG_BLANK_TICKS]   = 12'(RST_BLANK_TICKS);
    set_reg[REG_TIMEOUT_TICKS] = 12'(RST_TIMEOUT_TICKS);
    set_reg[REG_UNDOCKED_MIN]  = RST_UNDOCKED_MIN;
    set_reg[REG_PWR_ON_MIN]    = RST_PWR_ON_MIN;
    set_reg[REG_12V_MIN]       = RST_12V_MIN;
    set_reg[REG_5V_MIN]        = RST_5V_MIN;
    set_reg[REG_PWR_OFF_MAX]   = RST_PWR_OFF_MAX;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle tick and query, dock success, query in a run, restarts.
    queue_item(CMD_TICK, 12'hFFF, 12'h000, 1'b0);
    queue_item(CMD_QUERY, 12'h000, 12'hFFF, 1'b1);
    queue_item(CMD_DOCK, 12'hFFF, 12'hFFF, 1'b0);
    queue_item(CMD_QUERY, 12'h000, 12'd3100, 1'b0);
    queue_item(CMD_TICK, 12'hFFF, 12'hFFF, 1'b0);
    queue_item(CMD_TICK, 12'h000, 12'd2600, 1'b0);
    queue_item(CMD_UNDOCK, 12'h000, 12'd2000, 1'b0);
    queue_item(CMD_TICK, 12'h000, 12'd1500, 1'b0);
    queue_item(CMD_DOCK, 12'h000, 12'h000, 1'b1);
    queue_item(CMD_UNDOCK, 12'h000, 12'd1100, 1'b0);
    queue_item(CMD_TICK, 12'h000, 12'd1099, 1'b1);
    wait_drained();

    // Overcurrent with the blank setting at zero; a sample equal to the limit breaks the trip run.
    write_setting(REG_CURRENT_LIMIT, 12'd4094);
    write_setting(REG_BLANK_TICKS, 12'd0);
    queue_item(CMD_UNDOCK, 12'h000, 12'h000, 1'b0);
    queue_item(CMD_TICK, 12'hFFF, 12'h000, 1'b0);
    queue_item(CMD_TICK, 12'hFFF, 12'h000, 1'b0);
    queue_item(CMD_TICK, 12'hFFF, 12'h000, 1'b0);
    queue_item(CMD_TICK, 12'd4094, 12'h000, 1'b0);
    for (k = 0; k < 4; k++)
      queue_item(CMD_TICK, 12'hFFF, 12'h000, 1'b0);
    wait_drained();

    // A tick limit of zero behaves as one.
    write_setting(REG_TIMEOUT_TICKS, 12'd0);
    queue_item(CMD_DOCK, 12'h000, 12'hFFF, 1'b0);
    queue_item(CMD_TICK, 12'h000, 12'hFFF, 1'b0);
    wait_drained();

    // An oversized tick limit is clamped; run one undock all the way to its timeout.
    send_pause_on = 1'b0;
    recv_pause_on = 1'b0;
    write_setting(REG_CURRENT_LIMIT, 12'hFFF);
    write_setting(REG_BLANK_TICKS, 12'hFFF);
    write_setting(REG_TIMEOUT_TICKS, 12'hFFF);
    queue_item(CMD_UNDOCK, 12'h000, 12'h000, 1'b0);
    for (k = 0; k < RUN_TICK_CAP + 1; k++)
      queue_item(CMD_TICK, 12'($urandom), 12'($urandom), 1'b0);
    wait_drained();

    while (queued_total < ITEM_GOAL) begin
      program_random_settings();
      send_pause_on = ($urandom_range(0, 3) != 0);
      recv_pause_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(4, 10);
      for (k = 0; k < n; k++) begin
        queue_run($urandom_range(1, 40));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4))
            queue_item(cmd_t'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                       1'($urandom));
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
